>>> design/scan_reply_classifier_dedup_defines.svh
// Assertion macros shared by the scan reply classifier RTL.
`ifndef SCAN_REPLY_CLASSIFIER_DEDUP_DEFINES_SVH
`define SCAN_REPLY_CLASSIFIER_DEDUP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srcd assertion failed");
`define SRCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srcd assertion failed");
`else
`define SRCD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SRCD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/srcd_pkg.sv
// Shared constants and codes of the scan reply classifier.
package srcd_pkg;
   localparam int DEF_BITMAP_INDEX_BITS = 16;
   localparam int DEF_MAX_FRAME_BYTES   = 65535;
   localparam int POS_BITS              = 16;
   localparam int HDR_BYTES             = 128;
   localparam int HDR_ADDR_BITS         = 7;
   localparam int ROW_BIT_SEL           = 5;   // 32-bit rows in the seen bitmap
   localparam int ROW_WIDTH             = 32;

   localparam logic [15:0] VLAN_TPID  = 16'h8100;
   localparam logic [15:0] IPV4_TYPE  = 16'h0800;
   localparam logic [31:0] HASH_MUL_1 = 32'h85eb_ca6b;
   localparam logic [31:0] HASH_MUL_2 = 32'hc2b2_ae35;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [7:0] UNREACH_TYPE = 8'd3;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_SYNACK  = 3'd1;
   localparam logic [2:0] KIND_RST     = 3'd2;
   localparam logic [2:0] KIND_UDP     = 3'd3;
   localparam logic [2:0] KIND_UNREACH = 3'd4;

   localparam logic CSR_OWN_IP    = 1'b0;
   localparam logic CSR_MULTIPORT = 1'b1;
endpackage

>>> design/srcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/scan_reply_classifier_dedup.sv
// Scan reply classifier: frame parser, reply dedup bitmap and counters.
//
// Frame bytes enter on the req_ stream, one item per byte, starting at the
// destination MAC; req_tlast marks the final byte. Non-last bytes are taken
// at one per cycle. After the last byte the block drops req_tready and a
// sequencer reads 17 header bytes back from the header RAM (an issue and a
// capture state each), classifies the frame, runs the murmur finalizer on one
// shared 32x32 multiplier in multiport mode (shift-xor, multiply, shift-xor,
// multiply, shift-xor), and does a read-modify-write of one bitmap row. An
// ignored, RST or ICMP frame skips the hash and the bitmap; outside multiport
// mode a reply skips the hash. Every frame gives exactly one result item, ignored
// frames included. The result sits in an output register; the block goes back
// to taking bytes of the next frame while it waits. If the receiver stalls and
// the next frame completes, hold that frame's result until the register frees.
// After reset the seen bitmap is cleared one 32-bit row per cycle, all
// 2**(BITMAP_INDEX_BITS-5) rows (2048 by default), with req_tready low. The
// csr_ port writes own_ip (index 0) and multiport (index 1); the user must
// do so only while idle, as the block itself does not enforce it.
module scan_reply_classifier_dedup
   import srcd_pkg::*;
#(
   parameter int BITMAP_INDEX_BITS = DEF_BITMAP_INDEX_BITS,
   parameter int MAX_FRAME_BYTES   = DEF_MAX_FRAME_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // source_ip, source_port, reply_count, syn_ack_count, rst_count, unreach_count
   output logic [175:0] rsp_tdata,
   output logic [3:0]   rsp_tuser,   // reply_kind, first_sighting
   input  logic         csr_wen,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata
);
`include "scan_reply_classifier_dedup_defines.svh"

   localparam int ROW_BITS = BITMAP_INDEX_BITS - ROW_BIT_SEL;
   localparam int ROWS     = 2 ** ROW_BITS;
   localparam logic [POS_BITS-1:0] POS_MAX = POS_BITS'(MAX_FRAME_BYTES);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_ISSUE, ST_CAPT, ST_DECIDE,
      ST_HASH, ST_BM_RD, ST_BM_WR, ST_OUT
   } state_type;

   state_type state_ff;
   logic [POS_BITS-1:0] pos_ff, len_ff;
   logic [4:0]  step_ff;
   logic [2:0]  hstep_ff;
   logic [15:0] etype0_ff, vtype_ff, sport_ff;
   logic [3:0]  ihl_ff;
   logic [7:0]  proto_ff, flags_ff;
   logic [31:0] sip_ff, dst_ff, key_ff;
   logic [2:0]  kind_ff;
   logic        first_ff;
   logic [ROW_BITS-1:0] clr_ff;
   logic [31:0] own_ip_ff;
   logic        multiport_ff;
   logic [31:0] replies_ff, synacks_ff, resets_ff, unreach_ff;
   logic        rsp_valid_ff, rsp_first_ff;
   logic [2:0]  rsp_kind_ff;
   logic [31:0] rsp_sip_ff;
   logic [15:0] rsp_port_ff;

   // header RAM and bitmap RAM wiring
   logic [HDR_ADDR_BITS-1:0] hdr_waddr, hdr_raddr;
   logic        hdr_we;
   logic [7:0]  hdr_rdata;
   logic        bm_we;
   logic [ROW_BITS-1:0]  bm_waddr;
   logic [ROW_WIDTH-1:0] bm_wdata, bm_rdata;

   logic        req_acc, out_load;
   logic [POS_BITS-1:0] pos_in;
   logic [4:0]  off_c;
   logic [15:0] etype_c;
   logic [6:0]  l4_c;
   logic        ip_ok, tcp_ok, udp_ok, icmp_ok;
   logic [2:0]  kind_c;
   logic [31:0] mul_const, mul_q;
   logic [4:0]  bit_sel;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign pos_in     = (pos_ff < POS_MAX) ? pos_ff + 1'b1 : pos_ff;
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   assign hdr_we    = req_acc && (pos_ff < POS_BITS'(HDR_BYTES));
   assign hdr_waddr = pos_ff[HDR_ADDR_BITS-1:0];

   // frame offsets once the ethertype bytes are in
   always_comb begin
      if (etype0_ff == VLAN_TPID) begin
         off_c   = 5'd18;
         etype_c = (len_ff >= POS_BITS'(18)) ? vtype_ff : 16'h0000;
      end else begin
         off_c   = 5'd14;
         etype_c = etype0_ff;
      end
      l4_c = 7'(off_c) + {1'b0, ihl_ff, 2'b00};
   end

   always_comb begin
      if (step_ff == 5'd0) begin
         hdr_raddr = 7'd12;
      end else if (step_ff == 5'd1) begin
         hdr_raddr = 7'd13;
      end else if (step_ff == 5'd2) begin
         hdr_raddr = 7'd16;
      end else if (step_ff == 5'd3) begin
         hdr_raddr = 7'd17;
      end else if (step_ff == 5'd4) begin
         hdr_raddr = 7'(off_c);
      end else if (step_ff == 5'd5) begin
         hdr_raddr = 7'(off_c) + 7'd9;
      end else if (step_ff inside {[5'd6:5'd13]}) begin
         hdr_raddr = 7'(off_c) + 7'(step_ff) + 7'd6;   // source then destination
      end else if (step_ff == 5'd14) begin
         hdr_raddr = l4_c;
      end else if (step_ff == 5'd15) begin
         hdr_raddr = l4_c + 7'd1;
      end else begin
         hdr_raddr = l4_c + 7'd13;
      end
   end

   // classify from the gathered header fields
   always_comb begin
      ip_ok   = (len_ff >= POS_BITS'(14)) && (etype_c == IPV4_TYPE) &&
                ({1'b0, len_ff} >= 17'(off_c) + 17'd20) && (dst_ff == own_ip_ff);
      tcp_ok  = (proto_ff == PROTO_TCP)  && ({1'b0, len_ff} >= 17'(l4_c) + 17'd20);
      udp_ok  = (proto_ff == PROTO_UDP)  && ({1'b0, len_ff} >= 17'(l4_c) + 17'd8);
      icmp_ok = (proto_ff == PROTO_ICMP) && ({1'b0, len_ff} >= 17'(l4_c) + 17'd8);
      kind_c  = KIND_NONE;
      if (ip_ok) begin
         if (tcp_ok) begin
            if (flags_ff[1] && flags_ff[4]) begin
               kind_c = KIND_SYNACK;
            end else if (flags_ff[2]) begin
               kind_c = KIND_RST;
            end
         end else if (udp_ok) begin
            kind_c = KIND_UDP;
         end else if (icmp_ok && (sport_ff[15:8] == UNREACH_TYPE)) begin
            kind_c = KIND_UNREACH;
         end
      end
   end

   // shared multiplier of the hash finalizer
   assign mul_const = (hstep_ff == 3'd1) ? HASH_MUL_1 : HASH_MUL_2;
   assign mul_q     = key_ff * mul_const;

   assign bit_sel  = key_ff[ROW_BIT_SEL-1:0];
   assign bm_we    = (state_ff == ST_CLEAR) || (state_ff == ST_BM_WR);
   assign bm_waddr = (state_ff == ST_CLEAR) ? clr_ff : key_ff[BITMAP_INDEX_BITS-1:ROW_BIT_SEL];
   assign bm_wdata = (state_ff == ST_CLEAR) ? '0 : (bm_rdata | (ROW_WIDTH'(1) << bit_sel));

   srcd_ram #(.WIDTH(8), .DEPTH(HDR_BYTES)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hdr_waddr),
      .wr_data (req_tdata),
      .rd_addr (hdr_raddr),
      .rd_data (hdr_rdata)
   );

   srcd_ram #(.WIDTH(ROW_WIDTH), .DEPTH(ROWS)) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (key_ff[BITMAP_INDEX_BITS-1:ROW_BIT_SEL]),
      .rd_data (bm_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         len_ff       <= '0;
         step_ff      <= '0;
         hstep_ff     <= '0;
         own_ip_ff    <= '0;
         multiport_ff <= 1'b0;
         replies_ff   <= '0;
         synacks_ff   <= '0;
         resets_ff    <= '0;
         unreach_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_OWN_IP:    own_ip_ff    <= csr_wdata;
               CSR_MULTIPORT: multiport_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_tlast) begin
                     len_ff   <= pos_in;
                     pos_ff   <= '0;
                     step_ff  <= '0;
                     state_ff <= ST_ISSUE;
                  end else begin
                     pos_ff <= pos_in;
                  end
               end
            end
            ST_ISSUE: state_ff <= ST_CAPT;
            ST_CAPT: begin
               if (step_ff == 5'd0) begin
                  etype0_ff[15:8] <= hdr_rdata;
               end else if (step_ff == 5'd1) begin
                  etype0_ff[7:0] <= hdr_rdata;
               end else if (step_ff == 5'd2) begin
                  vtype_ff[15:8] <= hdr_rdata;
               end else if (step_ff == 5'd3) begin
                  vtype_ff[7:0] <= hdr_rdata;
               end else if (step_ff == 5'd4) begin
                  ihl_ff <= hdr_rdata[3:0];
               end else if (step_ff == 5'd5) begin
                  proto_ff <= hdr_rdata;
               end else if (step_ff inside {[5'd6:5'd9]}) begin
                  sip_ff <= {sip_ff[23:0], hdr_rdata};
               end else if (step_ff inside {[5'd10:5'd13]}) begin
                  dst_ff <= {hdr_rdata, dst_ff[31:8]};   // wire order, first byte low
               end else if (step_ff == 5'd14) begin
                  sport_ff[15:8] <= hdr_rdata;
               end else if (step_ff == 5'd15) begin
                  sport_ff[7:0] <= hdr_rdata;
               end else begin
                  flags_ff <= hdr_rdata;
               end
               if (step_ff == 5'd16) begin
                  state_ff <= ST_DECIDE;
               end else begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_DECIDE: begin
               kind_ff  <= kind_c;
               first_ff <= 1'b0;
               hstep_ff <= '0;
               if ((kind_c == KIND_SYNACK) || (kind_c == KIND_UDP)) begin
                  if (multiport_ff) begin
                     key_ff   <= sip_ff ^ {16'h0000, sport_ff};
                     state_ff <= ST_HASH;
                  end else begin
                     key_ff   <= sip_ff;
                     state_ff <= ST_BM_RD;
                  end
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_HASH: begin
               case (hstep_ff)
                  3'd0, 3'd4: key_ff <= key_ff ^ (key_ff >> 16);
                  3'd2:       key_ff <= key_ff ^ (key_ff >> 13);
                  default:    key_ff <= mul_q;
               endcase
               hstep_ff <= hstep_ff + 1'b1;
               if (hstep_ff == 3'd4) begin
                  state_ff <= ST_BM_RD;
               end
            end
            ST_BM_RD: state_ff <= ST_BM_WR;
            ST_BM_WR: begin
               first_ff <= !bm_rdata[bit_sel];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_load) begin
                  case (kind_ff)
                     KIND_SYNACK: begin
                        replies_ff <= replies_ff + 1'b1;
                        synacks_ff <= synacks_ff + 1'b1;
                     end
                     KIND_UDP:     replies_ff <= replies_ff + 1'b1;
                     KIND_RST:     resets_ff  <= resets_ff + 1'b1;
                     KIND_UNREACH: unreach_ff <= unreach_ff + 1'b1;
                     default: ;
                  endcase
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result payload, loaded in the same cycle as the counters update
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff  <= kind_ff;
         rsp_first_ff <= first_ff;
         rsp_sip_ff   <= (kind_ff == KIND_NONE) ? 32'h0 : sip_ff;
         rsp_port_ff  <= ((kind_ff == KIND_NONE) || (kind_ff == KIND_UNREACH)) ?
                         16'h0 : sport_ff;
      end
   end

   logic [31:0] out_replies, out_synacks, out_resets, out_unreach;
   assign out_replies = replies_ff;
   assign out_synacks = synacks_ff;
   assign out_resets  = resets_ff;
   assign out_unreach = unreach_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_first_ff, rsp_kind_ff};
   assign rsp_tdata  = {out_unreach, out_resets, out_synacks, out_replies,
                        rsp_port_ff, rsp_sip_ff};

   `SRCD_ASSERT_IMP(a_ignored_clean, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == KIND_NONE),
      !rsp_first_ff && (rsp_sip_ff == 32'h0) && (rsp_port_ff == 16'h0))
   `SRCD_ASSERT_IMP(a_first_on_reply, clock, reset,
      rsp_valid_ff && rsp_first_ff,
      (rsp_kind_ff == KIND_SYNACK) || (rsp_kind_ff == KIND_UDP))
   `SRCD_ASSERT_NXT(a_unreach_count, clock, reset,
      out_load && (kind_ff == KIND_UNREACH),
      unreach_ff == $past(unreach_ff) + 32'd1)
   `SRCD_ASSERT_IMP(a_pos_bound, clock, reset, 1'b1, pos_ff <= POS_MAX)
endmodule

>>> tb/sv/scan_reply_classifier_dedup_checker.sv
// Checker for the scan reply classifier: watches the channels, predicts and compares.
module scan_reply_classifier_dedup_checker
   import srcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [175:0] rsp_tdata,
   input  logic [3:0]   rsp_tuser,
   input  logic         csr_wen,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata,
   output int           fail_count,
   output int           replies_pending,
   output int           replies_seen
);

   typedef struct packed {
      logic [2:0]  kind;
      logic        first;
      logic [31:0] sip;
      logic [15:0] sport;
      logic [31:0] n_reply;
      logic [31:0] n_synack;
      logic [31:0] n_rst;
      logic [31:0] n_unreach;
   } reply_type;

   reply_type   reply_q[$];
   logic [7:0]  hdr[HDR_BYTES];
   int          frame_len;
   logic        seen[1 << DEF_BITMAP_INDEX_BITS];
   logic [31:0] tot_reply, tot_synack, tot_rst, tot_unreach;
   logic [31:0] my_ip;
   logic        multi;

   function automatic logic [15:0] be16(int i);
      return {hdr[i & (HDR_BYTES - 1)], hdr[(i + 1) & (HDR_BYTES - 1)]};
   endfunction

   function automatic logic [31:0] mix_hash(logic [31:0] ip, logic [15:0] port);
      logic [31:0] h;
      h = ip ^ {16'd0, port};
      h = h ^ (h >> 16);
      h = h * HASH_MUL_1;
      h = h ^ (h >> 13);
      h = h * HASH_MUL_2;
      h = h ^ (h >> 16);
      return h;
   endfunction

   function automatic logic mark_seen(logic [31:0] ip, logic [15:0] port);
      logic [31:0] key;
      logic        fresh;
      key = multi ? mix_hash(ip, port) : ip;
      fresh = !seen[key[DEF_BITMAP_INDEX_BITS-1:0]];
      seen[key[DEF_BITMAP_INDEX_BITS-1:0]] = 1'b1;
      return fresh;
   endfunction

   // Classify the finished frame and fold it into the counters.
   function automatic reply_type classify_frame();
      reply_type   r;
      int          len, off, l4;
      logic [15:0] etype;
      logic [7:0]  proto, flags;
      logic [31:0] dst;
      r = '0;
      len = frame_len;
      frame_len = 0;
      if (len >= 14) begin
         etype = be16(12);
         off = 14;
         if (etype == VLAN_TPID) begin
            if (len >= 18) begin
               etype = be16(16);
               off = 18;
            end else begin
               etype = 16'd0;
            end
         end
         dst = {be16(off + 18), be16(off + 16)};
         dst = {dst[23:16], dst[31:24], dst[7:0], dst[15:8]};
         if (etype == IPV4_TYPE && len >= off + 20 && dst == my_ip) begin
            l4 = off + int'(hdr[off][3:0]) * 4;
            proto = hdr[off + 9];
            r.sip = {be16(off + 12), be16(off + 14)};
            if (proto == PROTO_TCP && len >= l4 + 20) begin
               flags = hdr[(l4 + 13) & (HDR_BYTES - 1)];
               r.sport = be16(l4);
               if (flags[1] && flags[4]) begin
                  r.kind = KIND_SYNACK;
                  tot_reply++;
                  tot_synack++;
                  r.first = mark_seen(r.sip, r.sport);
               end else if (flags[2]) begin
                  r.kind = KIND_RST;
                  tot_rst++;
               end
            end else if (proto == PROTO_UDP && len >= l4 + 8) begin
               r.kind = KIND_UDP;
               r.sport = be16(l4);
               tot_reply++;
               r.first = mark_seen(r.sip, r.sport);
            end else if (proto == PROTO_ICMP && len >= l4 + 8) begin
               if (hdr[l4 & (HDR_BYTES - 1)] == UNREACH_TYPE) begin
                  r.kind = KIND_UNREACH;
                  tot_unreach++;
               end
            end
            if (r.kind == KIND_NONE) begin
               r.sip = '0;
               r.sport = '0;
            end
            if (r.kind == KIND_UNREACH) r.sport = '0;
         end
      end
      r.n_reply = tot_reply;
      r.n_synack = tot_synack;
      r.n_rst = tot_rst;
      r.n_unreach = tot_unreach;
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, want %0h at reply %0d", what, got, want,
               replies_seen);
      fail_count++;
   endtask

   always @(posedge clock) begin
      reply_type want, got;
      if (reset) begin
         foreach (hdr[i]) hdr[i] = '0;
         foreach (seen[i]) seen[i] = 1'b0;
         frame_len = 0;
         {tot_reply, tot_synack, tot_rst, tot_unreach} = '0;
         my_ip = '0;
         multi = 1'b0;
         reply_q.delete();
         fail_count = 0;
         replies_seen = 0;
      end else begin
         if (csr_wen) begin
            if (csr_addr == CSR_OWN_IP) my_ip = csr_wdata;
            else multi = csr_wdata[0];
         end
         // Predict from every accepted byte.
         if (req_tvalid && req_tready) begin
            if (frame_len < HDR_BYTES) hdr[frame_len] = req_tdata;
            if (frame_len < DEF_MAX_FRAME_BYTES) frame_len++;
            if (req_tlast) reply_q.push_back(classify_frame());
         end
         // Compare every accepted result with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser[2:0];
            got.first = rsp_tuser[3];
            {got.n_unreach, got.n_rst, got.n_synack, got.n_reply, got.sport, got.sip} =
               rsp_tdata;
            if (reply_q.size() == 0) begin
               report("unexpected reply", {29'd0, got.kind}, '0);
            end else begin
               want = reply_q.pop_front();
               if (got.kind != want.kind)
                  report("reply_kind", 32'(got.kind), 32'(want.kind));
               if (got.first != want.first)
                  report("first_sighting", 32'(got.first), 32'(want.first));
               if (got.sip != want.sip) report("source_ip", got.sip, want.sip);
               if (got.sport != want.sport)
                  report("source_port", 32'(got.sport), 32'(want.sport));
               if (got.n_reply != want.n_reply)
                  report("reply_count", got.n_reply, want.n_reply);
               if (got.n_synack != want.n_synack)
                  report("syn_ack_count", got.n_synack, want.n_synack);
               if (got.n_rst != want.n_rst) report("rst_count", got.n_rst, want.n_rst);
               if (got.n_unreach != want.n_unreach)
                  report("unreach_count", got.n_unreach, want.n_unreach);
            end
            replies_seen++;
         end
      end
      replies_pending = reply_q.size();
   end

endmodule

>>> tb/sv/scan_reply_classifier_dedup_test.sv
// Top of the scan reply classifier testbench: stimulus, receiver stalls and verdict.
module scan_reply_classifier_dedup_test;
   import srcd_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 80;   // margin for the block to settle after the last result
   localparam int TOTAL_BYTES = 1800;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [175:0] rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         csr_wen = 1'b0;
   logic         csr_addr = CSR_OWN_IP;
   logic [31:0]  csr_wdata = '0;
   int           fail_count, replies_pending, replies_seen;
   int           cycle_count = 0;
   int           burst_left = 0;
   int           bytes_total = 0;
   logic [31:0]  cur_ip;

   always #6 clock = ~clock;

   scan_reply_classifier_dedup dut (.*);

   scan_reply_classifier_dedup_checker checker_i (.*);

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: stall pattern that steps through four modes, plus one long
   // hold-off so the output register fills and the block stalls its input.
   always @(posedge clock) begin
      int mode;
      mode = (cycle_count / 300) % 4;
      if (cycle_count >= 2600 && cycle_count < 3800) rsp_tready <= 1'b0;
      else if (mode == 0) rsp_tready <= 1'b1;
      else if (mode == 1) rsp_tready <= ($urandom_range(0, 1) == 1);
      else if (mode == 2) rsp_tready <= ($urandom_range(0, 4) == 0);
      else rsp_tready <= ((cycle_count % 7) < 4);
   end

   // Offer one byte and hold it until taken; insert a random gap between bursts.
   task automatic send_byte(logic [7:0] b, logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 9) < 6) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame(logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
      bytes_total += q.size();
   endtask

   // Build a frame. proto/l4tag pick the layer-4 content; cut < 0 keeps it whole.
   task automatic make_frame(output logic [7:0] q[$], input logic [7:0] proto,
                             input logic [7:0] l4tag, input logic vlan, input int ihl,
                             input logic to_me, input logic good_type, input int cut);
      logic [31:0] dst;
      logic [7:0]  l4[20];
      q.delete();
      repeat (12) q.push_back(8'($urandom));
      if (vlan) begin
         q.push_back(8'h81); q.push_back(8'h00);
         q.push_back(8'($urandom)); q.push_back(8'($urandom));
      end
      if (good_type) begin
         q.push_back(8'h08); q.push_back(8'h00);
      end else begin
         q.push_back(8'($urandom)); q.push_back(8'($urandom));
      end
      q.push_back({4'h4, 4'(ihl)});
      repeat (8) q.push_back(8'($urandom));
      q.push_back(proto);
      repeat (2) q.push_back(8'($urandom));
      // Source address from a small pool so repeats hit the seen bitmap.
      if ($urandom_range(0, 9) < 7) begin
         q.push_back(8'd10); q.push_back(8'd0);
         q.push_back(8'($urandom_range(0, 1))); q.push_back(8'($urandom_range(0, 7)));
      end else begin
         repeat (4) q.push_back(8'($urandom));
      end
      dst = to_me ? cur_ip : $urandom;
      q.push_back(dst[7:0]); q.push_back(dst[15:8]);
      q.push_back(dst[23:16]); q.push_back(dst[31:24]);
      if (ihl > 5) repeat ((ihl - 5) * 4) q.push_back(8'($urandom));
      foreach (l4[i]) l4[i] = 8'($urandom);
      if ($urandom_range(0, 9) < 7) begin
         l4[0] = 8'd0;
         l4[1] = 8'($urandom_range(0, 3));
      end
      if (proto == PROTO_ICMP) l4[0] = l4tag;
      else l4[13] = l4tag;
      foreach (l4[i]) q.push_back(l4[i]);
      repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
      if (cut >= 1 && cut < q.size()) q = q[0:cut-1];
   endtask

   function automatic logic [7:0] tcp_flags(int sel);
      logic [7:0] f;
      f = 8'($urandom);
      if (sel == 0) f = f | 8'h12;
      else if (sel == 1) f = (f | 8'h04) & 8'hed;
      else f = f & 8'hf9;
      return f;
   endfunction

   // One random frame: mostly well formed replies, the rest broken or noise.
   task automatic random_frame(output logic [7:0] q[$]);
      int   sel, ihl, cut;
      logic [7:0] proto, tag;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         q.delete();
         repeat ($urandom_range(1, 70)) q.push_back(8'($urandom));
         return;
      end
      sel = $urandom_range(0, 5);
      case (sel)
         0, 1, 2: begin
            proto = PROTO_TCP;
            tag = tcp_flags($urandom_range(0, 2));
         end
         3: begin
            proto = PROTO_UDP;
            tag = 8'($urandom);
         end
         4: begin
            proto = PROTO_ICMP;
            tag = ($urandom_range(0, 3) != 0) ? UNREACH_TYPE : 8'($urandom);
         end
         default: begin
            proto = 8'($urandom);
            tag = 8'($urandom);
         end
      endcase
      ihl = ($urandom_range(0, 9) < 8) ? 5 : $urandom_range(0, 15);
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : -1;
      make_frame(q, proto, tag, $urandom_range(0, 3) == 0, ihl,
                 $urandom_range(0, 9) != 0, $urandom_range(0, 19) != 0, cut);
   endtask

   // Drain all predicted results, then let the block settle.
   task automatic settle();
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers on back-to-back cycles.
   task automatic configure(logic [31:0] ip, logic mp);
      cur_ip = ip;
      csr_wen <= 1'b1;
      csr_addr <= CSR_OWN_IP;
      csr_wdata <= ip;
      @(posedge clock);
      csr_addr <= CSR_MULTIPORT;
      csr_wdata <= {31'd0, mp};
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      logic [7:0]  q[$];
      logic [31:0] ips[4];
      int          bytes_sent;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: each reply kind, tagging, odd header lengths, short frames.
      configure(32'h0a00_a8c0, 1'b0);
      make_frame(q, PROTO_TCP, 8'h12, 1'b0, 5, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_TCP, 8'h12, 1'b0, 5, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_TCP, 8'h04, 1'b1, 5, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_TCP, 8'h18, 1'b0, 5, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_TCP, 8'hff, 1'b0, 15, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_UDP, 8'h00, 1'b1, 6, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_ICMP, UNREACH_TYPE, 1'b0, 5, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_ICMP, 8'd0, 1'b0, 5, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_UDP, 8'h00, 1'b0, 0, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_TCP, 8'h12, 1'b0, 3, 1'b1, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_UDP, 8'h00, 1'b0, 5, 1'b0, 1'b1, -1); send_frame(q);
      make_frame(q, PROTO_UDP, 8'h00, 1'b0, 5, 1'b1, 1'b0, -1); send_frame(q);
      // UDP one byte short
      make_frame(q, PROTO_UDP, 8'h00, 1'b0, 5, 1'b1, 1'b1, 41); send_frame(q);
      // TCP one byte short
      make_frame(q, PROTO_TCP, 8'h12, 1'b0, 5, 1'b1, 1'b1, 53); send_frame(q);
      make_frame(q, PROTO_ICMP, UNREACH_TYPE, 1'b1, 5, 1'b1, 1'b1, 45); send_frame(q);
      // cut right after the tag, before the inner ethertype
      make_frame(q, PROTO_UDP, 8'h00, 1'b1, 5, 1'b1, 1'b1, 16); send_frame(q);
      make_frame(q, PROTO_UDP, 8'h00, 1'b0, 5, 1'b1, 1'b1, 13); send_frame(q);
      make_frame(q, PROTO_UDP, 8'h00, 1'b0, 5, 1'b1, 1'b1, 1); send_frame(q);
      settle();

      // Random phases, extremes of both registers among them.
      ips[0] = 32'h0000_0000;
      ips[1] = 32'hffff_ffff;
      ips[2] = $urandom;
      ips[3] = $urandom;
      for (int p = 0; p < 4; p++) begin
         configure(ips[p], p[0]);
         bytes_sent = 0;
         while (bytes_sent < 150) begin
            random_frame(q);
            if ($urandom_range(0, 3) == 0) q[$] = 8'hff;
            send_frame(q);
            bytes_sent += q.size();
         end
         settle();
      end
      // Fill up the byte budget in multiport mode.
      configure(32'h0a00_a8c0, 1'b1);
      while (bytes_total < TOTAL_BYTES) begin
         random_frame(q);
         send_frame(q);
      end
      settle();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
